>>> rtl/nwt_pkg.sv
`default_nettype none

package nwt_pkg;

  localparam int AmountW      = 32;
  localparam int Digits       = 10;
  localparam int BcdW         = 4 * Digits;
  localparam int BitsPerStage = 8;
  localparam int DabbleStages = AmountW / BitsPerStage;
  localparam int WordW        = 5;
  localparam int Groups       = 4;
  localparam int SlotsPerGrp  = 5;
  localparam int SlotCnt      = Groups * SlotsPerGrp;

  localparam logic [WordW-1:0] WORD_ZERO     = 5'd0;
  localparam logic [WordW-1:0] WORD_TENS_OFS = 5'd18;
  localparam logic [WordW-1:0] WORD_HUNDRED  = 5'd28;
  localparam logic [WordW-1:0] WORD_THOUSAND = 5'd29;
  localparam logic [WordW-1:0] WORD_MILLION  = 5'd30;
  localparam logic [WordW-1:0] WORD_BILLION  = 5'd31;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic [SlotCnt-1:0]        mask;
    logic [SlotCnt-1:0][WordW-1:0] code;
  } slots_t;

endpackage

`default_nettype wire

>>> rtl/nwt_dabble.sv
`default_nettype none

module nwt_dabble
  import nwt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [AmountW-1:0] in_bin,
  input  logic [BcdW-1:0]    in_bcd,
  output logic               valid_r,
  output logic [AmountW-1:0] bin_r,
  output logic [BcdW-1:0]    bcd_r
);

  logic [AmountW-1:0] bin_nxt;
  logic [BcdW-1:0]    bcd_nxt;

  // shift-add-3 over a slice of the binary word
  always_comb begin
    logic [AmountW-1:0] b;
    logic [BcdW-1:0]    d;
    b = in_bin;
    d = in_bcd;
    for (int s = 0; s < BitsPerStage; s++) begin
      for (int k = 0; k < Digits; k++) begin
        if (d[k*4 +: 4] >= 4'd5) begin
          d[k*4 +: 4] = d[k*4 +: 4] + 4'd3;
        end
      end
      {d, b} = {d, b} << 1;
    end
    bin_nxt = b;
    bcd_nxt = d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/nwt_serializer.sv
`default_nettype none

module nwt_serializer
  import nwt_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load_valid,
  input  slots_t load,
  output logic   ready,
  output logic   tok_valid,
  output word_t  tok_code,
  output logic   tok_last
);

  logic [SlotCnt-1:0]            mask_r, mask_nxt;
  logic [SlotCnt-1:0][WordW-1:0] code_r;
  logic [SlotCnt-1:0]            pick;

  assign pick      = mask_r & (~mask_r + SlotCnt'(1));
  assign tok_valid = |mask_r;
  assign tok_last  = (mask_r & (mask_r - SlotCnt'(1))) == '0;
  assign ready     = !tok_valid || tok_last;

  always_comb begin
    tok_code = '0;
    for (int i = 0; i < SlotCnt; i++) begin
      if (pick[i]) begin
        tok_code = tok_code | code_r[i];
      end
    end
  end

  always_comb begin
    if (ready && load_valid) begin
      mask_nxt = load.mask;
    end else begin
      mask_nxt = mask_r & ~pick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load_valid) begin
      code_r <= load.code;
    end
  end

endmodule

`default_nettype wire

>>> rtl/number_to_word_tokens_top.sv
`default_nettype none

// Spells an unsigned 32-bit amount as English word tokens, most significant
// first, one token per cycle on out_word_code with out_valid high for that
// single cycle; out_last_word marks the final token of the amount. An amount
// is taken when start is high and busy is low, and one may enter every cycle
// while the pipeline has room. It runs through four binary-to-decimal stages
// (eight bits each), one stage that lays out the token slots, and then the
// token serializer, which puts each token on the outputs in turn.
// The serializer sends one token per cycle, and an amount spells as 1 to 16
// tokens; it loads the next amount while the current one's last token is out.
// The receiver cannot stall; busy rises only when every stage holds
// an amount and the serializer is not on its last token.
module number_to_word_tokens_top
  import nwt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [AmountW-1:0] in_amount,
  output logic               out_valid,
  output logic [WordW-1:0]   out_word_code,
  output logic               out_last_word
);

  function automatic slots_t build_slots(input logic [BcdW-1:0] bcd);
    slots_t     s;
    logic [3:0] h, t, u;
    int         base;
    s = '0;
    for (int g = 0; g < Groups; g++) begin
      base = g * SlotsPerGrp;
      if (g == 0) begin
        h = 4'd0;
        t = 4'd0;
        u = bcd[BcdW-4 +: 4];
      end else begin
        h = bcd[(Groups-1-g)*12 + 8 +: 4];
        t = bcd[(Groups-1-g)*12 + 4 +: 4];
        u = bcd[(Groups-1-g)*12 +: 4];
      end
      s.code[base]     = {1'b0, h};
      s.mask[base]     = h != 4'd0;
      s.code[base + 1] = WORD_HUNDRED;
      s.mask[base + 1] = h != 4'd0;
      s.code[base + 2] = WORD_TENS_OFS + {1'b0, t};
      s.mask[base + 2] = t >= 4'd2;
      if (t >= 4'd2) begin
        s.code[base + 3] = {1'b0, u};
        s.mask[base + 3] = u != 4'd0;
      end else begin
        s.code[base + 3] = (t != 4'd0) ? 5'd10 + {1'b0, u} : {1'b0, u};
        s.mask[base + 3] = (t != 4'd0) || (u != 4'd0);
      end
      case (g)
        0:       s.code[base + 4] = WORD_BILLION;
        1:       s.code[base + 4] = WORD_MILLION;
        default: s.code[base + 4] = WORD_THOUSAND;
      endcase
      s.mask[base + 4] = (g < Groups - 1) && ((h | t | u) != 4'd0);
    end
    if (bcd == '0) begin
      s.code[SlotCnt - 2] = WORD_ZERO;
      s.mask[SlotCnt - 2] = 1'b1;
    end
    return s;
  endfunction

  logic               v   [DabbleStages+1];
  logic [AmountW-1:0] bin [DabbleStages+1];
  logic [BcdW-1:0]    bcd [DabbleStages+1];
  logic [DabbleStages-1:0] en;

  logic   slot_valid_r;
  slots_t slot_r;
  logic   slot_en;
  logic   ser_ready;

  assign v[0]   = start;
  assign bin[0] = in_amount;
  assign bcd[0] = '0;

  for (genvar k = 0; k < DabbleStages; k++) begin : g_dab
    if (k == DabbleStages - 1) begin : g_end
      assign en[k] = !v[k+1] || slot_en;
    end else begin : g_mid
      assign en[k] = !v[k+1] || en[k+1];
    end
    nwt_dabble u_dab (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en[k]),
      .in_valid (v[k]),
      .in_bin   (bin[k]),
      .in_bcd   (bcd[k]),
      .valid_r  (v[k+1]),
      .bin_r    (bin[k+1]),
      .bcd_r    (bcd[k+1])
    );
  end

  assign busy    = !en[0];
  assign slot_en = !slot_valid_r || ser_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= 1'b0;
    end else if (slot_en) begin
      slot_valid_r <= v[DabbleStages];
    end
  end

  always_ff @(posedge clk) begin
    if (slot_en) begin
      slot_r <= build_slots(bcd[DabbleStages]);
    end
  end

  nwt_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (slot_valid_r),
    .load       (slot_r),
    .ready      (ser_ready),
    .tok_valid  (out_valid),
    .tok_code   (out_word_code),
    .tok_last   (out_last_word)
  );

  a_tokens_contiguous: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_word |=> out_valid
  ) else $error("token run of one amount broken");

  a_busy_only_mid_run: assert property (
    @(posedge clk) disable iff (!rst_n)
    busy |-> out_valid && !out_last_word && slot_valid_r
  ) else $error("busy while the serializer could take a beat");

  a_quiet_after_reset: assert property (
    @(posedge clk)
    $past(!rst_n) |-> !out_valid && !busy
  ) else $error("activity right after reset");

endmodule

`default_nettype wire
